/* src/ssf_pkg.sv */
// Shared types, constants and the segment lookup for the six-digit segment formatter.
// Used by every module in src; no dependencies.
package ssf_pkg;

   localparam int DIGIT_COUNT = 6;
   localparam int DIGIT_IDX_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] MODE_WEIGHT  = 2'd0;
   localparam logic [1:0] MODE_CAL_ALL = 2'd1;
   localparam logic [1:0] MODE_CAL_ONE = 2'd2;

   localparam logic [7:0]  MINUS_PATTERN = 8'h40;
   // ceil(2^35 / 10): v * DIV10_RECIP >> 35 == v / 10 for every 32-bit v
   localparam logic [31:0] DIV10_RECIP   = 32'hCCCC_CCCD;
   localparam int          DIV10_SHIFT   = 35;

   typedef struct packed {
      logic [1:0]  mode;
      logic [31:0] magnitude;
      logic        negative;
      logic [2:0]  selected_digit;
   } req_type;

   typedef struct packed {
      logic [2:0] digit_index;
      logic [7:0] segments;
      logic       last_digit;
   } rsp_type;

   // one converted item waiting for the back end
   typedef struct packed {
      logic [1:0]                   mode;
      logic                         negative;
      logic [2:0]                   selected_digit;
      logic [DIGIT_COUNT-1:0][3:0]  digits;
      logic [DIGIT_COUNT-1:0]       show;
   } entry_type;

   typedef struct packed {
      logic      push;
      entry_type entry;
   } push_type;

   function automatic logic [7:0] seg_pattern(input logic [3:0] digit);
      logic [7:0] pat;
      unique case (digit)
         4'd0:    pat = 8'h3F;
         4'd1:    pat = 8'h06;
         4'd2:    pat = 8'h5B;
         4'd3:    pat = 8'h4F;
         4'd4:    pat = 8'h66;
         4'd5:    pat = 8'h6D;
         4'd6:    pat = 8'h7D;
         4'd7:    pat = 8'h07;
         4'd8:    pat = 8'h7F;
         4'd9:    pat = 8'h6F;
         default: pat = 8'h00;
      endcase
      return pat;
   endfunction

endpackage

/* src/signed_six_digit_segment_formatter.sv */
// Top level of the six-digit segment formatter: front converter, entry FIFO, digit emitter.
// Depends on ssf_pkg, ssf_front, ssf_queue and ssf_back.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid / req_ready | req_data (ssf_pkg::req_type)
//   rsp     | out       | rsp_valid / rsp_ready | rsp_data (ssf_pkg::rsp_type)
//
// The front converts an item with a divide-by-ten step that yields one digit per cycle;
// the back end issues one digit item per cycle while rsp_ready allows, up to 6 per item.
// A two-entry FIFO between them lets each side stall alone.
// Reserved modes and out-of-range selected digits are accepted and produce nothing.
// Reset is synchronous and clears only control state.
module signed_six_digit_segment_formatter (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ssf_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ssf_pkg::rsp_type  rsp_data
);

   ssf_pkg::push_type  push;
   logic               push_ready;
   logic               head_valid;
   ssf_pkg::entry_type head_entry;
   logic               pop;

   ssf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push_out   (push),
      .push_ready (push_ready)
   );

   ssf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_in    (push),
      .push_ready (push_ready),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop)
   );

   ssf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

/* src/ssf_front.sv */
// Front end: accepts requests, drops meaningless ones and peels off one decimal digit a cycle.
// Depends on ssf_pkg.
module ssf_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ssf_pkg::req_type  req_data,
   output ssf_pkg::push_type push_out,
   input  logic              push_ready
);

   logic                                          busy_ff, busy_in;
   logic [ssf_pkg::DIGIT_IDX_W-1:0]               count_ff, count_in;
   logic [31:0]                                   value_ff, value_in;
   logic [1:0]                                    mode_ff, mode_in;
   logic                                          neg_ff, neg_in;
   logic [2:0]                                    sel_ff, sel_in;
   logic [ssf_pkg::DIGIT_COUNT-1:0][3:0]          digits_ff, digits_in;
   logic [ssf_pkg::DIGIT_COUNT-1:0]               show_ff, show_in;

   logic [63:0] product;
   logic [31:0] quotient;
   logic [3:0]  remainder;
   logic        at_last;
   logic        accept;
   logic        item_ok;
   logic        done;

   assign product   = 64'(value_ff) * 64'(ssf_pkg::DIV10_RECIP);
   assign quotient  = 32'(product[63:ssf_pkg::DIV10_SHIFT]);
   assign remainder = 4'(value_ff - ((quotient << 3) + (quotient << 1)));

   assign at_last   = busy_ff && (count_ff == ssf_pkg::DIGIT_IDX_W'(ssf_pkg::DIGIT_COUNT - 1));
   assign done      = at_last && push_ready;
   assign req_ready = !busy_ff || done;
   assign accept    = req_valid && req_ready;

   // classify: reserved mode and an out-of-range selected digit produce nothing
   always_comb begin
      item_ok = 1'b0;
      priority if (req_data.mode == ssf_pkg::MODE_WEIGHT) begin
         item_ok = 1'b1;
      end else if (req_data.mode == ssf_pkg::MODE_CAL_ALL) begin
         item_ok = 1'b1;
      end else if (req_data.mode == ssf_pkg::MODE_CAL_ONE) begin
         item_ok = ({1'b0, req_data.selected_digit} < 4'(ssf_pkg::DIGIT_COUNT));
      end else begin
         item_ok = 1'b0;
      end
   end

   always_comb begin
      busy_in   = busy_ff;
      count_in  = count_ff;
      value_in  = value_ff;
      mode_in   = mode_ff;
      neg_in    = neg_ff;
      sel_in    = sel_ff;
      digits_in = digits_ff;
      show_in   = show_ff;
      if (busy_ff && !at_last) begin
         digits_in[count_ff] = remainder;
         show_in[count_ff]   = (value_ff != 32'd0);
         value_in            = quotient;
         count_in            = count_ff + 1'b1;
      end
      if (done) begin
         busy_in = 1'b0;
      end
      if (accept && item_ok) begin
         busy_in  = 1'b1;
         count_in = '0;
         value_in = req_data.magnitude;
         mode_in  = req_data.mode;
         neg_in   = req_data.negative;
         sel_in   = req_data.selected_digit;
      end
   end

   // the final digit is merged straight into the pushed entry
   always_comb begin
      push_out.push                     = done;
      push_out.entry.mode               = mode_ff;
      push_out.entry.negative           = neg_ff;
      push_out.entry.selected_digit     = sel_ff;
      push_out.entry.digits             = digits_ff;
      push_out.entry.show               = show_ff;
      push_out.entry.digits[count_ff]   = remainder;
      push_out.entry.show[count_ff]     = (value_ff != 32'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff  <= value_in;
      mode_ff   <= mode_in;
      neg_ff    <= neg_in;
      sel_ff    <= sel_in;
      digits_ff <= digits_in;
      show_ff   <= show_in;
   end

`ifndef ASSERT_OFF
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (count_ff <= ssf_pkg::DIGIT_IDX_W'(ssf_pkg::DIGIT_COUNT - 1)))
      else $error("front digit counter out of range");
   a_drop_reserved: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_data.mode != ssf_pkg::MODE_WEIGHT) &&
       (req_data.mode != ssf_pkg::MODE_CAL_ALL) &&
       (req_data.mode != ssf_pkg::MODE_CAL_ONE)) |=> !busy_ff)
      else $error("reserved mode started a conversion");
`endif

endmodule

/* src/ssf_queue.sv */
// Short FIFO of converted entries between the front and back ends.
// Depends on ssf_pkg.
module ssf_queue (
   input  logic                clock,
   input  logic                reset,
   input  ssf_pkg::push_type   push_in,
   output logic                push_ready,
   output logic                head_valid,
   output ssf_pkg::entry_type  head_entry,
   input  logic                pop
);

   ssf_pkg::entry_type                store_ff [ssf_pkg::QUEUE_DEPTH];
   logic [ssf_pkg::QPTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [ssf_pkg::QPTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [ssf_pkg::QCNT_W-1:0]        count_ff, count_in;
   logic                              do_push;
   logic                              do_pop;

   assign push_ready = (count_ff != ssf_pkg::QCNT_W'(ssf_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = store_ff[rd_ptr_ff];
   assign do_push    = push_in.push && push_ready;
   assign do_pop     = pop && head_valid;

   function automatic logic [ssf_pkg::QPTR_W-1:0] next_ptr(
      input logic [ssf_pkg::QPTR_W-1:0] ptr);
      logic [ssf_pkg::QPTR_W-1:0] nxt;
      if (ptr == ssf_pkg::QPTR_W'(ssf_pkg::QUEUE_DEPTH - 1)) begin
         nxt = '0;
      end else begin
         nxt = ptr + 1'b1;
      end
      return nxt;
   endfunction

   always_comb begin
      wr_ptr_in = do_push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_in.entry;
      end
   end

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= ssf_pkg::QCNT_W'(ssf_pkg::QUEUE_DEPTH))
      else $error("queue count above depth");
   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not advance on push");
`endif

endmodule

/* src/ssf_back.sv */
// Back end: walks the head entry and registers one digit drive item a cycle unless rsp_ready stalls.
// Depends on ssf_pkg.
module ssf_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  ssf_pkg::entry_type head_entry,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output ssf_pkg::rsp_type   rsp_data
);

   logic [ssf_pkg::DIGIT_IDX_W-1:0] step_ff, step_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   ssf_pkg::rsp_type                rsp_data_ff, rsp_data_in;
   ssf_pkg::rsp_type                item;
   logic                            load;
   logic                            final_step;
   logic                            top_step;
   logic [2:0]                      pos;

   assign top_step   = (step_ff == ssf_pkg::DIGIT_IDX_W'(ssf_pkg::DIGIT_COUNT - 1));
   assign final_step = top_step || (head_entry.mode == ssf_pkg::MODE_CAL_ONE);
   assign load       = head_valid && (!rsp_valid_ff || rsp_ready);
   assign pop        = load && final_step;

   always_comb begin
      pos  = 3'(step_ff);
      item = '0;
      priority if (head_entry.mode == ssf_pkg::MODE_WEIGHT) begin
         pos              = 3'(step_ff);
         item.last_digit  = top_step;
         if (head_entry.negative && top_step) begin
            item.segments = ssf_pkg::MINUS_PATTERN;
         end else if ((step_ff == '0) || head_entry.show[step_ff]) begin
            item.segments = ssf_pkg::seg_pattern(head_entry.digits[step_ff]);
         end else begin
            item.segments = 8'h00;
         end
      end else if (head_entry.mode == ssf_pkg::MODE_CAL_ALL) begin
         // scan from the top position down
         pos              = 3'(ssf_pkg::DIGIT_COUNT - 1) - 3'(step_ff);
         item.last_digit  = top_step;
         item.segments    =
            ssf_pkg::seg_pattern(head_entry.digits[pos[ssf_pkg::DIGIT_IDX_W-1:0]]);
      end else begin
         pos              = head_entry.selected_digit;
         item.last_digit  = 1'b1;
         item.segments    =
            ssf_pkg::seg_pattern(head_entry.digits[pos[ssf_pkg::DIGIT_IDX_W-1:0]]);
      end
      item.digit_index = pos;
   end

   always_comb begin
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = item;
         step_in      = final_step ? '0 : step_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef ASSERT_OFF
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      step_ff <= ssf_pkg::DIGIT_IDX_W'(ssf_pkg::DIGIT_COUNT - 1))
      else $error("back step counter out of range");
   a_entry_kept: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.last_digit) |-> head_valid)
      else $error("entry retired before its last digit");
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ({1'b0, rsp_data_ff.digit_index} < 4'(ssf_pkg::DIGIT_COUNT)))
      else $error("digit index beyond display");
   a_step_clear: assert property (@(posedge clock) disable iff (reset)
      pop |=> (step_ff == '0))
      else $error("step not cleared after retiring an entry");
`endif

endmodule

/* dv/signed_six_digit_segment_formatter_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the six-digit segment formatter: queued stimulus, random idling
// on both channels, digit-item prediction and in-order checking. Depends on ssf_pkg.
module signed_six_digit_segment_formatter_tb;

   localparam logic [1:0] MODE_RESERVED  = 2'd3;
   localparam int RANDOM_ITEMS    = 187;
   localparam int SETTLE_CYCLES   = 16;
   localparam int LONG_HOLD_AT    = 150;
   localparam int LONG_HOLD_LEN   = 300;
   localparam int WATCHDOG_LIMIT  = 4000;

   localparam logic [7:0] SEG_GLYPH [10] = '{
      8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
   };
   localparam logic [31:0] DECADES [10] = '{
      32'd1, 32'd10, 32'd100, 32'd1000, 32'd10000, 32'd100000,
      32'd1000000, 32'd10000000, 32'd100000000, 32'd1000000000
   };

   typedef struct {
      ssf_pkg::req_type item;
      bit               drain_first;
   } backlog_entry_type;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   ssf_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   ssf_pkg::rsp_type rsp_data;

   backlog_entry_type req_backlog[$];
   ssf_pkg::rsp_type  expected_digits[$];
   int                error_count = 0;
   int                idle_cycles = 0;

   signed_six_digit_segment_formatter uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [3:0] digit_at(input logic [31:0] value, input int pos);
      logic [31:0] v;
      v = value;
      for (int i = 0; i < pos; i++) v = v / 10;
      return 4'(v % 10);
   endfunction

   // expected digit items for one accepted request, in emission order
   task automatic predict_digits(input ssf_pkg::req_type item);
      logic [7:0]       pat [ssf_pkg::DIGIT_COUNT];
      logic [31:0]      rest;
      int               span;
      ssf_pkg::rsp_type r;
      case (item.mode)
         ssf_pkg::MODE_WEIGHT: begin
            rest = item.magnitude;
            span = item.negative ? ssf_pkg::DIGIT_COUNT - 1 : ssf_pkg::DIGIT_COUNT;
            for (int p = 0; p < ssf_pkg::DIGIT_COUNT; p++) begin
               pat[p] = 8'h00;
               // blank leading zeros, but always show the units digit
               if (p < span && (rest != 0 || p == 0)) begin
                  pat[p] = SEG_GLYPH[rest % 10];
                  rest = rest / 10;
               end
            end
            if (item.negative) pat[ssf_pkg::DIGIT_COUNT-1] = ssf_pkg::MINUS_PATTERN;
            for (int p = 0; p < ssf_pkg::DIGIT_COUNT; p++) begin
               r.digit_index = 3'(p);
               r.segments    = pat[p];
               r.last_digit  = (p == ssf_pkg::DIGIT_COUNT - 1);
               expected_digits.push_back(r);
            end
         end
         ssf_pkg::MODE_CAL_ALL: begin
            for (int p = ssf_pkg::DIGIT_COUNT - 1; p >= 0; p--) begin
               r.digit_index = 3'(p);
               r.segments    = SEG_GLYPH[digit_at(item.magnitude, p)];
               r.last_digit  = (p == 0);
               expected_digits.push_back(r);
            end
         end
         ssf_pkg::MODE_CAL_ONE: begin
            if (item.selected_digit < ssf_pkg::DIGIT_COUNT) begin
               r.digit_index = item.selected_digit;
               r.segments    = SEG_GLYPH[digit_at(item.magnitude, int'(item.selected_digit))];
               r.last_digit  = 1'b1;
               expected_digits.push_back(r);
            end
         end
         default: ;
      endcase
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
      error_count++;
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [31:0] pick_magnitude();
      logic [31:0] p;
      case ($urandom_range(0, 9))
         0, 1, 2: return $urandom;
         3:       return $urandom_range(0, 9);
         4:       return $urandom_range(0, 99999);
         5:       return $urandom_range(0, 999999);
         6: begin
            p = DECADES[$urandom_range(0, 9)];
            return p + $urandom_range(0, 2) - 1;
         end
         7:       return 32'd0;
         8:       return 32'hFFFF_FFFF - $urandom_range(0, 5);
         default: return $urandom_range(0, 999);
      endcase
   endfunction

   task automatic queue_item(input logic [1:0] mode, input logic [31:0] magnitude,
                             input logic negative, input logic [2:0] sel,
                             input bit drain_first);
      backlog_entry_type e;
      e.item.mode           = mode;
      e.item.magnitude      = magnitude;
      e.item.negative       = negative;
      e.item.selected_digit = sel;
      e.drain_first         = drain_first;
      req_backlog.push_back(e);
   endtask

   // driver: present backlog items, hold payload until transfer
   int  req_gap = 0;
   int  req_burst = 0;
   int  quiet_cycles = 0;
   always @(posedge clock) begin
      logic offer;
      backlog_entry_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
         req_gap = 0;
         quiet_cycles = 0;
      end else begin
         offer = req_valid;
         if (req_valid && req_ready) begin
            predict_digits(req_data);
            offer = 1'b0;
            if (req_burst > 0) begin
               req_gap = 0;
               req_burst--;
            end else begin
               req_gap = pick_gap();
               if ($urandom_range(0, 19) == 0) req_burst = $urandom_range(10, 30);
            end
         end
         if (expected_digits.size() == 0 && !req_valid) quiet_cycles++;
         else quiet_cycles = 0;
         if (!offer) begin
            if (req_gap > 0) begin
               req_gap--;
            end else if (req_backlog.size() > 0) begin
               // hold a drain point until the block has gone quiet
               if (!req_backlog[0].drain_first ||
                   (expected_digits.size() == 0 && quiet_cycles >= SETTLE_CYCLES)) begin
                  nxt = req_backlog.pop_front();
                  req_data <= nxt.item;
                  offer = 1'b1;
               end
            end
         end
         req_valid <= offer;
      end
   end

   // monitor: check each result transfer and pace rsp_ready
   int  rsp_hold = 0;
   int  rsp_burst = 0;
   int  results_seen = 0;
   bit  long_hold_done = 0;
   always @(posedge clock) begin
      ssf_pkg::rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_hold = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (expected_digits.size() == 0) begin
               report_mismatch("unexpected digit item", int'(rsp_data), 0);
            end else begin
               want = expected_digits.pop_front();
               if (rsp_data.digit_index !== want.digit_index)
                  report_mismatch("digit_index", int'(rsp_data.digit_index),
                                  int'(want.digit_index));
               if (rsp_data.segments !== want.segments)
                  report_mismatch("segments", int'(rsp_data.segments), int'(want.segments));
               if (rsp_data.last_digit !== want.last_digit)
                  report_mismatch("last_digit", int'(rsp_data.last_digit),
                                  int'(want.last_digit));
            end
            if (!long_hold_done && results_seen == LONG_HOLD_AT) begin
               // long back-pressure so the block fills and stalls its input
               rsp_hold = LONG_HOLD_LEN;
               long_hold_done = 1;
            end else if (rsp_hold == 0) begin
               if (rsp_burst > 0) begin
                  rsp_burst--;
               end else begin
                  rsp_hold = pick_gap();
                  if ($urandom_range(0, 19) == 0) rsp_burst = $urandom_range(10, 30);
               end
            end
         end else if (rsp_hold == 0 && $urandom_range(0, 15) == 0) begin
            rsp_hold = $urandom_range(1, 3);
         end
         if (rsp_hold > 0) begin
            rsp_ready <= 1'b0;
            rsp_hold--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int         counted;
      logic [1:0] mode;
      logic [2:0] sel;
      bit         drain;

      // weight view: blanking, truncation, minus sign, negative zero
      queue_item(ssf_pkg::MODE_WEIGHT, 32'd0,          1'b0, 3'd0, 0);
      queue_item(ssf_pkg::MODE_WEIGHT, 32'd0,          1'b1, 3'd7, 0);
      queue_item(ssf_pkg::MODE_WEIGHT, 32'd7,          1'b0, 3'd0, 0);
      queue_item(ssf_pkg::MODE_WEIGHT, 32'd105,        1'b1, 3'd0, 0);
      queue_item(ssf_pkg::MODE_WEIGHT, 32'd999999,     1'b0, 3'd0, 0);
      queue_item(ssf_pkg::MODE_WEIGHT, 32'd1000000,    1'b0, 3'd0, 0);
      queue_item(ssf_pkg::MODE_WEIGHT, 32'd99999,      1'b1, 3'd0, 0);
      queue_item(ssf_pkg::MODE_WEIGHT, 32'd100000,     1'b1, 3'd0, 0);
      queue_item(ssf_pkg::MODE_WEIGHT, 32'hFFFF_FFFF,  1'b0, 3'd5, 0);
      queue_item(ssf_pkg::MODE_WEIGHT, 32'hFFFF_FFFF,  1'b1, 3'd2, 0);
      // calibration scan, negative flag must be ignored
      queue_item(ssf_pkg::MODE_CAL_ALL, 32'd0,         1'b1, 3'd0, 0);
      queue_item(ssf_pkg::MODE_CAL_ALL, 32'd123456,    1'b0, 3'd7, 0);
      queue_item(ssf_pkg::MODE_CAL_ALL, 32'hFFFF_FFFF, 1'b1, 3'd3, 0);
      // single selected digit, including out-of-range selects and reserved mode
      for (int s = 0; s < 8; s++)
         queue_item(ssf_pkg::MODE_CAL_ONE, 32'd987654, 1'(s & 1), 3'(s), s == 0);
      queue_item(MODE_RESERVED, 32'hFFFF_FFFF, 1'b1, 3'd7, 0);
      queue_item(ssf_pkg::MODE_CAL_ONE, 32'd4294967, 1'b0, 3'd5, 0);

      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7, 8: mode = ssf_pkg::MODE_WEIGHT;
            9, 10, 11, 12:             mode = ssf_pkg::MODE_CAL_ALL;
            13, 14, 15, 16, 17, 18:    mode = ssf_pkg::MODE_CAL_ONE;
            default:                   mode = MODE_RESERVED;
         endcase
         sel = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7))
                                           : 3'($urandom_range(0, 5));
         drain = (counted == 100);
         queue_item(mode, pick_magnitude(), 1'($urandom_range(0, 1)), sel, drain);
         counted++;
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      do @(posedge clock);
      while (req_backlog.size() != 0 || req_valid || expected_digits.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (error_count == 0 && expected_digits.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
